@@ design/psh_pkg.sv @@
// ----------------------------------------------------------------------------
// psh_pkg: shared types and constants for the patch header scanner
// marker bytes, phase codes, word types and the marker match step
// ----------------------------------------------------------------------------
`default_nettype none

package psh_pkg;

  localparam int MAX_NAME_DEF = 1023;

  localparam int NAME_W  = 10;
  localparam int OFF_W   = 32;
  localparam int IDX_W   = 16;
  localparam int MATCH_W = 3;
  localparam int PHASE_W = 2;

  localparam logic [PHASE_W-1:0] PH_SEEK_HEAD = 2'd0;
  localparam logic [PHASE_W-1:0] PH_NAME      = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SKIP      = 2'd2;
  localparam logic [PHASE_W-1:0] PH_SEEK_END  = 2'd3;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  localparam logic KIND_NAME   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [MATCH_W-1:0] MARK_LEN = 3'd5;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic             out_kind;
    logic [7:0]       out_byte;
    logic [OFF_W-1:0] out_start;
    logic [OFF_W-1:0] out_end;
    logic [IDX_W-1:0] out_index;
  } result_t;

  // input stage to core
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // core to result register
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_word_t;

  // marker byte at a position; minus selects the section marker
  function automatic logic [7:0] mark_byte(input logic minus, input logic [MATCH_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:         b = CH_NL;
      3'd1, 3'd2, 3'd3: b = minus ? CH_MINUS : CH_PLUS;
      3'd4:         b = CH_SPACE;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

  // one step of the marker match; a stray newline restarts at one
  function automatic logic [MATCH_W-1:0] advance_match(input logic minus,
                                                       input logic [MATCH_W-1:0] idx,
                                                       input logic [7:0] c);
    logic [MATCH_W-1:0] r;
    if (idx < MARK_LEN && c == mark_byte(minus, idx)) begin
      r = idx + 3'd1;
    end else if (c == CH_NL) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/psh_if.sv @@
// ----------------------------------------------------------------------------
// psh_in_if / psh_out_if: valid-ready channels of the patch header scanner
// one input word per handshake, one result word per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface psh_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] in_byte;

  modport source (output valid, output opcode, output in_byte, input ready);
  modport sink   (input valid, input opcode, input in_byte, output ready);
endinterface

interface psh_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [31:0] out_start;
  logic [31:0] out_end;
  logic [15:0] out_index;

  modport source (output valid, output out_kind, output out_byte, output out_start,
                  output out_end, output out_index, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_start,
                  input out_end, input out_index, output ready);
endinterface

`default_nettype wire

@@ design/psh_in_reg.sv @@
// ----------------------------------------------------------------------------
// psh_in_reg: input register of the patch header scanner
// holds one accepted word until the core consumes it
// ----------------------------------------------------------------------------
`default_nettype none

module psh_in_reg (
  input  wire logic        clk,
  input  wire logic        rst,
  psh_in_if.sink           in_ch,
  input  wire logic        fire,
  output psh_pkg::stage_t  stage
);

  logic          valid;
  psh_pkg::item_t item;

  assign in_ch.ready = !valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item.opcode  <= in_ch.opcode;
      item.in_byte <= in_ch.in_byte;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

`default_nettype wire

@@ design/psh_core.sv @@
// ----------------------------------------------------------------------------
// psh_core: scan state and per-word update of the patch header scanner
// marker hunt, name streaming, line skip and record building
// ----------------------------------------------------------------------------
`default_nettype none

module psh_core #(
  parameter int MAX_NAME = psh_pkg::MAX_NAME_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire psh_pkg::stage_t stage,
  input  wire logic          out_free,
  output logic               fire,
  output psh_pkg::res_word_t res_word
);

  localparam logic [psh_pkg::NAME_W-1:0] NAME_LIMIT = psh_pkg::NAME_W'(MAX_NAME);
  localparam logic [psh_pkg::OFF_W-1:0]  OFF_MAX    = '1;

  logic [psh_pkg::PHASE_W-1:0] phase, phase_next;
  logic [psh_pkg::MATCH_W-1:0] match_index, match_index_next;
  logic [psh_pkg::NAME_W-1:0]  name_length, name_length_next;
  logic [psh_pkg::OFF_W-1:0]   byte_offset, byte_offset_next;
  logic [psh_pkg::OFF_W-1:0]   section_start, section_start_next;
  logic [psh_pkg::IDX_W-1:0]   record_count, record_count_next;

  logic [7:0]                  c;
  logic [psh_pkg::OFF_W-1:0]   off_inc;
  logic [psh_pkg::OFF_W-1:0]   back;
  logic [psh_pkg::MATCH_W-1:0] adv;
  logic                        name_end;

  assign fire = stage.valid && out_free;
  assign c    = stage.item.in_byte;

  always_comb begin
    phase_next          = phase;
    match_index_next    = match_index;
    name_length_next    = name_length;
    byte_offset_next    = byte_offset;
    section_start_next  = section_start;
    record_count_next   = record_count;
    res_word            = '0;
    off_inc             = (byte_offset != OFF_MAX) ? byte_offset + 32'd1 : byte_offset;
    back                = {29'd0, match_index} - 32'd1;
    adv                 = psh_pkg::advance_match(phase == psh_pkg::PH_SEEK_END,
                                                 match_index, c);
    name_end            = (c inside {psh_pkg::CH_TAB, psh_pkg::CH_SPACE, psh_pkg::CH_NL}) ||
                          (name_length >= NAME_LIMIT);

    if (stage.item.opcode == psh_pkg::OP_EOS) begin
      if (phase == psh_pkg::PH_SEEK_END) begin
        res_word.valid         = 1'b1;
        res_word.res.out_kind  = psh_pkg::KIND_RECORD;
        res_word.res.out_start = section_start;
        res_word.res.out_index = record_count;
        if (match_index == 3'd0) begin
          res_word.res.out_end = byte_offset;
        end else begin
          res_word.res.out_end = (byte_offset >= back) ? byte_offset - back : 32'd0;
        end
      end
      // a new stream starts from scratch
      phase_next         = psh_pkg::PH_SEEK_HEAD;
      match_index_next   = '0;
      name_length_next   = '0;
      byte_offset_next   = '0;
      section_start_next = '0;
      record_count_next  = '0;
    end else begin
      byte_offset_next = off_inc;
      case (phase)
        psh_pkg::PH_SEEK_HEAD: begin
          if (adv == psh_pkg::MARK_LEN) begin
            match_index_next = '0;
            name_length_next = '0;
            phase_next       = psh_pkg::PH_NAME;
          end else begin
            match_index_next = adv;
          end
        end
        psh_pkg::PH_NAME: begin
          if (name_end) begin
            if (c == psh_pkg::CH_NL) begin
              section_start_next = off_inc;
              match_index_next   = 3'd1;
              phase_next         = psh_pkg::PH_SEEK_END;
            end else begin
              phase_next = psh_pkg::PH_SKIP;
            end
          end else begin
            res_word.valid        = 1'b1;
            res_word.res.out_kind = psh_pkg::KIND_NAME;
            res_word.res.out_byte = c;
            name_length_next      = name_length + 10'd1;
          end
        end
        psh_pkg::PH_SKIP: begin
          if (c == psh_pkg::CH_NL) begin
            section_start_next = off_inc;
            match_index_next   = 3'd1;
            phase_next         = psh_pkg::PH_SEEK_END;
          end
        end
        default: begin
          if (adv == psh_pkg::MARK_LEN) begin
            // end points just past the newline of the marker
            res_word.valid         = 1'b1;
            res_word.res.out_kind  = psh_pkg::KIND_RECORD;
            res_word.res.out_start = section_start;
            res_word.res.out_end   = (off_inc >= 32'd4) ? off_inc - 32'd4 : 32'd0;
            res_word.res.out_index = record_count;
            record_count_next      = record_count + 16'd1;
            match_index_next       = '0;
            phase_next             = psh_pkg::PH_SEEK_HEAD;
          end else begin
            match_index_next = adv;
          end
        end
      endcase
    end

    if (!fire) begin
      res_word.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= psh_pkg::PH_SEEK_HEAD;
      match_index   <= '0;
      name_length   <= '0;
      byte_offset   <= '0;
      section_start <= '0;
      record_count  <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      match_index   <= match_index_next;
      name_length   <= name_length_next;
      byte_offset   <= byte_offset_next;
      section_start <= section_start_next;
      record_count  <= record_count_next;
    end
  end

endmodule

`default_nettype wire

@@ design/psh_out_reg.sv @@
// ----------------------------------------------------------------------------
// psh_out_reg: result register of the patch header scanner
// holds one result word until the receiver takes it
// ----------------------------------------------------------------------------
`default_nettype none

module psh_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire psh_pkg::res_word_t res_word,
  output logic                   out_free,
  psh_out_if.source              out_ch
);

  logic             valid;
  psh_pkg::result_t res;

  assign out_free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= res_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_word.valid) begin
      res <= res_word.res;
    end
  end

  assign out_ch.valid     = valid;
  assign out_ch.out_kind  = res.out_kind;
  assign out_ch.out_byte  = res.out_byte;
  assign out_ch.out_start = res.out_start;
  assign out_ch.out_end   = res.out_end;
  assign out_ch.out_index = res.out_index;

endmodule

`default_nettype wire

@@ design/patch_header_scanner.sv @@
// ----------------------------------------------------------------------------
// patch_header_scanner: finds file sections in a patch byte stream
// streams each target file name out and reports one record per section
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per handshake: a data byte (opcode 0) or an
//   end-of-stream mark (opcode 1). out_ch carries result words: a file name
//   byte (out_kind 0) or a completed section record (out_kind 1) with start,
//   end and sequence index. A word causes zero or one result.
//   Throughput is one input word per cycle, sustained while the receiver keeps
//   taking results. An accepted word is held in the input register until the
//   core fires it; the core then updates the scan state and loads the result
//   register, and a result shows on out_ch from the result register until the
//   receiver takes it. The sustained rate rests on the state update loop
//   (match index, phase, counters), which the core computes combinationally.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; in_ch.ready then drops until out_ch moves again.
//   rst (synchronous) empties both registers and returns the scan to the
//   header hunt with all offsets and counts at zero. End of stream resets the
//   scan state the same way after flushing any open record.
// ----------------------------------------------------------------------------
`default_nettype none

module patch_header_scanner #(
  parameter int MAX_NAME = psh_pkg::MAX_NAME_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  psh_in_if.sink    in_ch,
  psh_out_if.source out_ch
);

  psh_pkg::stage_t    stage;
  psh_pkg::res_word_t res_word;
  logic               fire;
  logic               out_free;

  psh_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .fire  (fire),
    .stage (stage)
  );

  psh_core #(
    .MAX_NAME (MAX_NAME)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .out_free (out_free),
    .fire     (fire),
    .res_word (res_word)
  );

  psh_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res_word (res_word),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: patch header scanner
// sends patch byte streams, predicts every name byte and section record,
// and checks each result word in order under random sender and receiver gaps
// ----------------------------------------------------------------------------

module testbench;

  localparam int NAME_LIMIT   = psh_pkg::MAX_NAME_DEF;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;

  psh_in_if  in_ch ();
  psh_out_if out_ch ();

  patch_header_scanner #(.MAX_NAME(NAME_LIMIT)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // scan state of the predictor
  logic [psh_pkg::PHASE_W-1:0] scan_phase;
  logic [psh_pkg::MATCH_W-1:0] mark_pos;
  logic [psh_pkg::NAME_W-1:0]  name_len;
  logic [psh_pkg::OFF_W-1:0]   offset;
  logic [psh_pkg::OFF_W-1:0]   sect_start;
  logic [psh_pkg::IDX_W-1:0]   rec_count;

  psh_pkg::result_t pending_results[$];
  int               mismatches;
  int               idle_cycles;
  int               words_sent;
  int               send_idle_pct;
  int               recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_scan();
    scan_phase = psh_pkg::PH_SEEK_HEAD;
    mark_pos   = '0;
    name_len   = '0;
    offset     = '0;
    sect_start = '0;
    rec_count  = '0;
  endfunction

  function automatic logic [psh_pkg::MATCH_W-1:0] next_mark_pos(
      input logic minus, input logic [psh_pkg::MATCH_W-1:0] pos, input logic [7:0] c);
    logic [7:0] want;
    if (pos == 3'd0) begin
      want = psh_pkg::CH_NL;
    end else if (pos == 3'd4) begin
      want = psh_pkg::CH_SPACE;
    end else begin
      want = minus ? psh_pkg::CH_MINUS : psh_pkg::CH_PLUS;
    end
    if (pos < psh_pkg::MARK_LEN && c == want) begin
      return pos + 3'd1;
    end
    return (c == psh_pkg::CH_NL) ? 3'd1 : 3'd0;
  endfunction

  function automatic psh_pkg::result_t make_record(input logic [psh_pkg::OFF_W-1:0] end_off);
    psh_pkg::result_t r;
    r.out_kind  = psh_pkg::KIND_RECORD;
    r.out_byte  = 8'h00;
    r.out_start = sect_start;
    r.out_end   = end_off;
    r.out_index = rec_count;
    rec_count   = rec_count + 16'd1;
    return r;
  endfunction

  // advances the scan by one word; returns 1 when the word makes a result
  function automatic bit predict_word(input logic op, input logic [7:0] c,
                                      output psh_pkg::result_t r);
    logic [psh_pkg::OFF_W-1:0]   end_off;
    logic [psh_pkg::MATCH_W-1:0] back;
    bit                          made;
    made = 1'b0;
    r    = '0;
    if (op == psh_pkg::OP_EOS) begin
      if (scan_phase == psh_pkg::PH_SEEK_END) begin
        end_off = offset;
        if (mark_pos >= 3'd1) begin
          back    = mark_pos - 3'd1;
          end_off = (offset >= 32'(back)) ? offset - 32'(back) : '0;
        end
        r    = make_record(end_off);
        made = 1'b1;
      end
      clear_scan();
      return made;
    end
    if (offset != 32'hFFFF_FFFF) begin
      offset = offset + 32'd1;
    end
    case (scan_phase)
      psh_pkg::PH_SEEK_HEAD: begin
        mark_pos = next_mark_pos(1'b0, mark_pos, c);
        if (mark_pos == psh_pkg::MARK_LEN) begin
          mark_pos   = '0;
          name_len   = '0;
          scan_phase = psh_pkg::PH_NAME;
        end
      end
      psh_pkg::PH_NAME: begin
        if ((c inside {psh_pkg::CH_TAB, psh_pkg::CH_SPACE, psh_pkg::CH_NL}) ||
            int'(name_len) >= NAME_LIMIT) begin
          if (c == psh_pkg::CH_NL) begin
            sect_start = offset;
            mark_pos   = 3'd1;
            scan_phase = psh_pkg::PH_SEEK_END;
          end else begin
            scan_phase = psh_pkg::PH_SKIP;
          end
        end else begin
          r.out_kind = psh_pkg::KIND_NAME;
          r.out_byte = c;
          made       = 1'b1;
          name_len   = name_len + 10'd1;
        end
      end
      psh_pkg::PH_SKIP: begin
        if (c == psh_pkg::CH_NL) begin
          sect_start = offset;
          mark_pos   = 3'd1;
          scan_phase = psh_pkg::PH_SEEK_END;
        end
      end
      default: begin
        mark_pos = next_mark_pos(1'b1, mark_pos, c);
        if (mark_pos == psh_pkg::MARK_LEN) begin
          r          = make_record((offset >= 32'd4) ? offset - 32'd4 : '0);
          made       = 1'b1;
          mark_pos   = '0;
          scan_phase = psh_pkg::PH_SEEK_HEAD;
        end
      end
    endcase
    return made;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver gaps
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // prediction on accepted input words, checking of result words, watchdog
  always @(posedge clk) begin
    psh_pkg::result_t want;
    bit               moved;
    if (rst) begin
      clear_scan();
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        if (predict_word(in_ch.opcode, in_ch.in_byte, want)) begin
          pending_results.push_back(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d byte %0h",
                 out_ch.out_kind, out_ch.out_byte);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_kind", 32'(want.out_kind), 32'(out_ch.out_kind));
          check_field("out_byte", 32'(want.out_byte), 32'(out_ch.out_byte));
          check_field("out_start", want.out_start, out_ch.out_start);
          check_field("out_end", want.out_end, out_ch.out_end);
          check_field("out_index", 32'(want.out_index), 32'(out_ch.out_index));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("patch_header_scanner verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(psh_pkg::OP_DATA, s[i]);
    end
  endtask

  task automatic send_eos();
    send_word(psh_pkg::OP_EOS, 8'($urandom_range(255)));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // byte mix that makes markers and near misses common
  function automatic logic [7:0] patch_byte();
    case ($urandom_range(9))
      0, 1:    return psh_pkg::CH_NL;
      2:       return psh_pkg::CH_PLUS;
      3:       return psh_pkg::CH_MINUS;
      4:       return psh_pkg::CH_SPACE;
      5:       return psh_pkg::CH_TAB;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_name_terminators();
    send_text("\n+++ ");
    send_word(psh_pkg::OP_DATA, 8'hFF);
    send_word(psh_pkg::OP_DATA, 8'h00);
    send_text("\tx\n--- ");
    send_text("\n+++ n n\n\n--- ");
    send_text("\n+++ z\n--- ");
  endtask

  task automatic test_newline_restart();
    send_text("\n+\n+++ q\n-\n--- ");
  endtask

  task automatic test_end_of_stream();
    send_eos();
    send_text("\n+++ e");
    send_eos();
    send_text("\n+++ e\t");
    send_eos();
    send_text("\n+++ e\nab");
    send_eos();
    send_text("\n+++ e\n--");
    send_eos();
    send_text("\n+++ e\n");
    send_eos();
  endtask

  task automatic test_long_name();
    // one byte past the limit ends the name and the line is skipped
    send_text("\n+++ ");
    for (int i = 0; i < NAME_LIMIT; i++) begin
      send_word(psh_pkg::OP_DATA, 8'($urandom_range(8'h21, 8'h7E)));
    end
    send_text("Qrest\n--- ");
    // limit reached, then a newline ends the line at once
    send_text("\n+++ ");
    for (int i = 0; i < NAME_LIMIT; i++) begin
      send_word(psh_pkg::OP_DATA, 8'($urandom_range(8'h21, 8'hFF)));
    end
    send_text("\n--- ");
    send_eos();
  endtask

  task automatic random_section();
    int tail;
    repeat ($urandom_range(6)) send_word(psh_pkg::OP_DATA, patch_byte());
    if ($urandom_range(9) == 0) begin
      send_eos();
    end
    if ($urandom_range(7) == 0) begin
      send_text("\n++");
    end
    send_text("\n+++ ");
    repeat ($urandom_range(10)) begin
      if ($urandom_range(3) == 0) begin
        send_word(psh_pkg::OP_DATA, 8'($urandom_range(255)));
      end else begin
        send_word(psh_pkg::OP_DATA, 8'($urandom_range(8'h21, 8'hFF)));
      end
    end
    case ($urandom_range(3))
      0:       send_word(psh_pkg::OP_DATA, psh_pkg::CH_TAB);
      1:       send_word(psh_pkg::OP_DATA, psh_pkg::CH_SPACE);
      2:       send_eos();
      default: ;
    endcase
    repeat ($urandom_range(3)) send_word(psh_pkg::OP_DATA, 8'($urandom_range(255)));
    send_word(psh_pkg::OP_DATA, psh_pkg::CH_NL);
    repeat ($urandom_range(20)) send_word(psh_pkg::OP_DATA, patch_byte());
    tail = $urandom_range(9);
    if (tail < 8) begin
      send_text("\n--- ");
    end else if (tail == 8) begin
      send_text("\n--");
      send_eos();
    end else begin
      send_eos();
    end
  endtask

  task automatic test_random_traffic();
    int goal;
    goal = words_sent + 200;
    send_idle_pct = 18;
    recv_idle_pct = 67;
    while (words_sent < goal) random_section();
    wait_for_results();
    goal = words_sent + 200;
    send_idle_pct = 67;
    recv_idle_pct = 18;
    while (words_sent < goal) random_section();
    goal = words_sent + 200;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_sent < goal) random_section();
  endtask

  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = psh_pkg::OP_DATA;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    mismatches    = 0;
    words_sent    = 0;
    send_idle_pct = 18;
    recv_idle_pct = 67;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_name_terminators();
    test_newline_restart();
    test_end_of_stream();
    test_long_name();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("patch_header_scanner verification clean");
    end else begin
      $display("patch_header_scanner verification failed");
    end
    $finish;
  end

endmodule
